// ===== src/ovrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ovrs_pkg
// Shared types and constants for the overwriting ring stack.
// ----------------------------------------------------------------------------
package ovrs_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ARG_W  = 5;
  localparam int unsigned LVL_W  = 5;
  // widths for the wrap and compare arithmetic
  localparam int unsigned AW     = ((PTR_W > ARG_W) ? PTR_W : ARG_W) + 1;
  localparam int unsigned CW     = (CNT_W > ARG_W) ? CNT_W : ARG_W;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_DROP  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [DATA_W-1:0] push_value;
    logic [ARG_W-1:0]  depth_arg;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [LVL_W-1:0]  fill_level;
  } out_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic             use_rd;
    logic [CNT_W-1:0] fill;
  } res_t;

endpackage

// ===== src/ovrs_ram.sv =====
// ----------------------------------------------------------------------------
// ovrs_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module ovrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ovrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ovrs_ctrl
// Top pointer and fill count; issues the RAM access and the result control.
// ----------------------------------------------------------------------------
module ovrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ovrs_pkg::in_t     item_i,
  output ovrs_pkg::mem_req_t mem_req_o,
  output ovrs_pkg::res_t    res_o
);

  logic [ovrs_pkg::PTR_W-1:0] top_q, top_d;
  logic [ovrs_pkg::CNT_W-1:0] cnt_q, cnt_d;
  ovrs_pkg::res_t             res_q, res_d;

  logic [ovrs_pkg::PTR_W-1:0] top_inc, top_dec, peek_addr;
  logic [ovrs_pkg::AW-1:0]    top_w, arg_w;
  logic [ovrs_pkg::CW-1:0]    cnt_c, arg_c;
  logic                       full, empty, peek_ok, drop_all;

  always_comb begin
    top_inc = (top_q == ovrs_pkg::PTR_W'(ovrs_pkg::DEPTH - 1)) ? '0 : top_q + 1'b1;
    top_dec = (top_q == '0) ? ovrs_pkg::PTR_W'(ovrs_pkg::DEPTH - 1) : top_q - 1'b1;
    top_w   = ovrs_pkg::AW'(top_q);
    arg_w   = ovrs_pkg::AW'(item_i.depth_arg);
    if (top_w >= arg_w) begin
      peek_addr = ovrs_pkg::PTR_W'(top_w - arg_w);
    end else begin
      peek_addr = ovrs_pkg::PTR_W'(top_w + ovrs_pkg::AW'(ovrs_pkg::DEPTH) - arg_w);
    end
    cnt_c    = ovrs_pkg::CW'(cnt_q);
    arg_c    = ovrs_pkg::CW'(item_i.depth_arg);
    full     = (cnt_q == ovrs_pkg::CNT_W'(ovrs_pkg::DEPTH));
    empty    = (cnt_q == '0);
    peek_ok  = (arg_c < cnt_c);
    drop_all = (cnt_c <= arg_c);
  end

  always_comb begin
    top_d           = top_q;
    cnt_d           = cnt_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = top_q;
    mem_req_o.wdata = item_i.push_value;
    res_d.valid     = accept_i;
    res_d.ok        = 1'b0;
    res_d.use_rd    = 1'b0;
    if (accept_i) begin
      case (ovrs_pkg::cmd_e'(item_i.command))
        ovrs_pkg::CMD_PUSH: begin
          top_d          = top_inc;
          mem_req_o.we   = 1'b1;
          mem_req_o.addr = top_inc;
          if (!full) begin
            cnt_d = cnt_q + 1'b1;
          end
          res_d.ok = 1'b1;
        end
        ovrs_pkg::CMD_POP: begin
          if (!empty) begin
            mem_req_o.re = 1'b1;
            top_d        = top_dec;
            cnt_d        = cnt_q - 1'b1;
            res_d.ok     = 1'b1;
            res_d.use_rd = 1'b1;
          end
        end
        ovrs_pkg::CMD_PEEK: begin
          mem_req_o.addr = peek_addr;
          if (peek_ok) begin
            mem_req_o.re = 1'b1;
            res_d.ok     = 1'b1;
            res_d.use_rd = 1'b1;
          end
        end
        ovrs_pkg::CMD_DROP: begin
          cnt_d    = drop_all ? '0 : ovrs_pkg::CNT_W'(cnt_c - arg_c);
          res_d.ok = 1'b1;
        end
        ovrs_pkg::CMD_CLEAR: begin
          top_d    = '0;
          cnt_d    = '0;
          res_d.ok = 1'b1;
        end
        default: begin
        end
      endcase
    end
    res_d.fill = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      cnt_q <= '0;
      res_q <= '0;
    end else begin
      top_q <= top_d;
      cnt_q <= cnt_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== src/overwriting_ring_stack.sv =====
// ----------------------------------------------------------------------------
// overwriting_ring_stack
// LIFO over a ring of words; a push into a full ring overwrites the oldest.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i and raise start_i; the item is taken at the
//   rising edge where start_i is high and busy_o is low. busy_o stays low,
//   so a new item may be issued every cycle.
//   Result channel: one result per item, on result_o for exactly one cycle
//   with result_valid_o high, in the cycle after the item was taken.
//   Throughput is one item per cycle; the result is registered in the control
//   block, and read data comes from the registered read of the entry RAM.
//   Pop reads the top entry, peek the entry depth_arg below the top; push
//   writes the next entry. Each item makes at most one RAM access.
//   Reset empties the stack (top pointer and fill count to zero); the RAM
//   content is not cleared and is never read before it is written.
//   The receiver cannot stall: results must be taken when strobed.
// ----------------------------------------------------------------------------
module overwriting_ring_stack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  ovrs_pkg::in_t  cmd_i,
  output logic           result_valid_o,
  output ovrs_pkg::out_t result_o
);

  logic                        accept;
  ovrs_pkg::mem_req_t          mem_req;
  ovrs_pkg::res_t              res;
  logic [ovrs_pkg::DATA_W-1:0] rdata;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  ovrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (cmd_i),
    .mem_req_o (mem_req),
    .res_o     (res)
  );

  ovrs_ram #(
    .WIDTH (ovrs_pkg::DATA_W),
    .DEPTH (ovrs_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  assign result_valid_o      = res.valid;
  assign result_o.ok         = res.ok;
  assign result_o.read_value = res.use_rd ? rdata : '0;
  assign result_o.fill_level = ovrs_pkg::LVL_W'(res.fill);

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result without an accepted item");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.ok) |-> (result_o.read_value == '0))
    else $error("failed item returned nonzero data");

  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.command == ovrs_pkg::CMD_PUSH)) |=>
      (result_o.ok && (result_o.fill_level != '0)))
    else $error("push did not succeed");
`endif

endmodule

// ===== verif/tb_overwriting_ring_stack.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overwriting_ring_stack
// Self-checking bench for the overwriting ring stack. A behavioral stack
// tracks every accepted item. Each strobed result is compared field by field
// with the oldest expected one. Directed items cover the empty stack, a full
// ring overwriting its oldest word and the edge depths. A long random run
// with bursty issue gaps follows.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_stack;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 4;

  // encodings the block does not define
  localparam logic [2:0] CMD_UNDEF_LO  = 3'd5;
  localparam logic [2:0] CMD_UNDEF_MID = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI  = 3'd7;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  ovrs_pkg::in_t  cmd_i;
  logic           result_valid_o;
  ovrs_pkg::out_t result_o;

  overwriting_ring_stack i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // behavioral copy of the stack
  logic [ovrs_pkg::DATA_W-1:0] ring_words [ovrs_pkg::DEPTH];
  logic [ovrs_pkg::PTR_W-1:0]  ring_top  = '0;
  logic [ovrs_pkg::CNT_W-1:0]  ring_fill = '0;

  ovrs_pkg::out_t pending_results [$];
  int unsigned    mismatch_count  = 0;
  int unsigned    item_count      = 0;
  int unsigned    result_count    = 0;
  int unsigned    overwrite_count = 0;
  int unsigned    refused_count   = 0;
  int unsigned    cycle_count     = 0;
  bit             idle_enable     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic ovrs_pkg::out_t stack_predict(ovrs_pkg::in_t item);
    ovrs_pkg::out_t             res;
    logic [ovrs_pkg::PTR_W-1:0] slot;
    res = '0;
    case (item.command)
      ovrs_pkg::CMD_PUSH: begin
        ring_top             = ring_top + 1'b1;
        ring_words[ring_top] = item.push_value;
        if (ring_fill < ovrs_pkg::DEPTH) ring_fill = ring_fill + 1'b1;
        res.ok = 1'b1;
      end
      ovrs_pkg::CMD_POP: begin
        if (ring_fill != 0) begin
          res.read_value = ring_words[ring_top];
          ring_top       = ring_top - 1'b1;
          ring_fill      = ring_fill - 1'b1;
          res.ok         = 1'b1;
        end
      end
      ovrs_pkg::CMD_PEEK: begin
        if (item.depth_arg < ring_fill) begin
          slot           = ring_top - item.depth_arg[ovrs_pkg::PTR_W-1:0];
          res.read_value = ring_words[slot];
          res.ok         = 1'b1;
        end
      end
      ovrs_pkg::CMD_DROP: begin
        ring_fill = (ring_fill <= item.depth_arg) ? '0 : ring_fill - item.depth_arg;
        res.ok    = 1'b1;
      end
      ovrs_pkg::CMD_CLEAR: begin
        ring_top  = '0;
        ring_fill = '0;
        res.ok    = 1'b1;
      end
      default: ;
    endcase
    res.fill_level = ring_fill;
    return res;
  endfunction

  // result check first, then the item taken at this edge
  always @(posedge clk_i) begin
    ovrs_pkg::out_t exp_res;
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        result_count++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: unexpected result ok=%0b read=%h level=%0d",
                     result_o.ok, result_o.read_value, result_o.fill_level);
        end else begin
          exp_res = pending_results.pop_front();
          if (result_o.ok !== exp_res.ok || result_o.read_value !== exp_res.read_value ||
              result_o.fill_level !== exp_res.fill_level) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"ERROR: result %0d exp ok=%0b read=%h level=%0d,",
                        " got ok=%0b read=%h level=%0d"},
                       result_count, exp_res.ok, exp_res.read_value, exp_res.fill_level,
                       result_o.ok, result_o.read_value, result_o.fill_level);
          end
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        item_count++;
        if (cmd_i.command == ovrs_pkg::CMD_PUSH && ring_fill == ovrs_pkg::DEPTH)
          overwrite_count++;
        exp_res = stack_predict(cmd_i);
        if (!exp_res.ok) refused_count++;
        pending_results.push_back(exp_res);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_enable || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(logic [2:0] command, logic [ovrs_pkg::DATA_W-1:0] value,
                           logic [ovrs_pkg::ARG_W-1:0] arg);
    ovrs_pkg::in_t item;
    int unsigned   gap;
    item.command    = command;
    item.push_value = value;
    item.depth_arg  = arg;
    cmd_i   <= item;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic test_empty_stack();
    send_item(ovrs_pkg::CMD_POP, $urandom, ovrs_pkg::ARG_W'($urandom));
    send_item(ovrs_pkg::CMD_PEEK, $urandom, '0);
    send_item(ovrs_pkg::CMD_DROP, '0, '1);
    send_item(CMD_UNDEF_MID, $urandom, '0);
    send_item(CMD_UNDEF_HI, '1, '1);
  endtask

  // one push more than the ring holds, then edge depths on the full ring
  task automatic test_overwrite_when_full();
    send_item(ovrs_pkg::CMD_PUSH, '0, '0);
    send_item(ovrs_pkg::CMD_PUSH, '1, '1);
    repeat (ovrs_pkg::DEPTH - 1)
      send_item(ovrs_pkg::CMD_PUSH, $urandom, ovrs_pkg::ARG_W'($urandom));
    send_item(ovrs_pkg::CMD_PEEK, $urandom, ovrs_pkg::ARG_W'(ovrs_pkg::DEPTH - 1));
    send_item(ovrs_pkg::CMD_PEEK, $urandom, ovrs_pkg::ARG_W'(ovrs_pkg::DEPTH));
    send_item(ovrs_pkg::CMD_POP, $urandom, '0);
    send_item(ovrs_pkg::CMD_DROP, $urandom, ovrs_pkg::ARG_W'(2));
    send_item(ovrs_pkg::CMD_CLEAR, $urandom, '1);
  endtask

  task automatic test_random_ops(int unsigned num_items);
    int unsigned                roll;
    logic [2:0]                 command;
    logic [ovrs_pkg::ARG_W-1:0] arg;
    repeat (num_items) begin
      roll = $urandom_range(0, 99);
      arg  = ovrs_pkg::ARG_W'($urandom);
      if (roll < 38) begin
        command = ovrs_pkg::CMD_PUSH;
      end else if (roll < 58) begin
        command = ovrs_pkg::CMD_POP;
      end else if (roll < 80) begin
        command = ovrs_pkg::CMD_PEEK;
        // mostly near the live region, hitting the count itself too
        if ($urandom_range(0, 3) != 0) arg = ovrs_pkg::ARG_W'($urandom_range(0, ring_fill));
      end else if (roll < 88) begin
        command = ovrs_pkg::CMD_DROP;
        if ($urandom_range(0, 4) != 0) arg = ovrs_pkg::ARG_W'($urandom_range(0, 3));
      end else if (roll < 92) begin
        command = ovrs_pkg::CMD_CLEAR;
      end else begin
        command = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      end
      send_item(command, $urandom, arg);
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    cmd_i   = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_enable = 1'b1;
    test_empty_stack();
    test_overwrite_when_full();
    test_random_ops(300);
    idle_enable = 1'b0;
    test_random_ops(100);
    idle_enable = 1'b1;
    test_random_ops(150);
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d items, checked %0d results over %0d cycles", item_count,
             result_count, cycle_count);
    $display("  %0d pushes onto a full ring, %0d refused or undefined items",
             overwrite_count, refused_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad results", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
